>>> sv/ste_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ste_pkg;

  // default geometry and height width
  localparam int DEF_MAX_COLS    = 64;
  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_HEIGHT_BITS = 32;

  // fixed 3x3 spread kernel
  localparam int KERNEL_SIZE = 3;
  localparam int KERNEL_TAPS = KERNEL_SIZE * KERNEL_SIZE;
  localparam int WEIGHT_W    = 4;
  localparam int SUM_W       = 8;

  // port field widths
  localparam int MODE_W     = 3;
  localparam int COORD_W    = 6;
  localparam int GRAIN_W    = 32;
  localparam int LIMIT_W    = 32;
  localparam int PEND_W     = 13;
  localparam int HOUT_W     = 32;
  localparam int SHADE_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 36;
  localparam int GRID_W     = 7;
  localparam int KW_W       = 36;

  localparam int SHADE_FULL = 255;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL      = 2'd2;

  // register reset values
  localparam logic [GRID_W-1:0] RST_GRID_WIDTH  = 7'd64;
  localparam logic [GRID_W-1:0] RST_GRID_HEIGHT = 7'd64;
  localparam logic [KW_W-1:0]   RST_KERNEL      = 36'h010101010;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_QALL  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RUN   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_ADD_WR,
    ST_QA_RD,
    ST_QA_WR,
    ST_POP_CHK,
    ST_POP_Q,
    ST_POP_CELL,
    ST_TOP_DIV,
    ST_NB_RD,
    ST_NB_WR,
    ST_RD_CELL,
    ST_RD_DIV1,
    ST_RD_DIV2,
    ST_CLR_RD,
    ST_CLR_WR,
    ST_DONE
  } state_t;

  // sum of the nine kernel weights
  function automatic logic [SUM_W-1:0] kernel_sum(input logic [KW_W-1:0] kw);
    logic [SUM_W-1:0] s;
    s = '0;
    for (int k = 0; k < KERNEL_TAPS; k++) begin
      s = s + SUM_W'(kw[WEIGHT_W*k +: WEIGHT_W]);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

>>> sv/sandpile_topple_engine_unit.sv
// operations: add, read (height plus a shade from two serial divisions), queue-all over the
// active grid, clear of the whole height memory, and run, which pops queued cells and topples
// each one with the serial divider and read-modify-writes of up to nine neighbour cells.
// one transaction in flight; the next is taken as soon as the result is in the output register.
// reset: synchronous, then a clearing pass over all MAX_COLS*MAX_ROWS cells (4096 by default)
// of the height memory, during which in_stall stays high.
`timescale 1ns / 1ps
`default_nettype none

module sandpile_topple_engine_unit #(
  parameter int MAX_COLS    = ste_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS    = ste_pkg::DEF_MAX_ROWS,
  parameter int HEIGHT_BITS = ste_pkg::DEF_HEIGHT_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ste_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ste_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ste_pkg::MODE_W-1:0]      mode,
  input  logic [ste_pkg::COORD_W-1:0]     col,
  input  logic [ste_pkg::COORD_W-1:0]     row,
  input  logic [ste_pkg::GRAIN_W-1:0]     grains,
  input  logic [ste_pkg::LIMIT_W-1:0]     pop_limit,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ste_pkg::PEND_W-1:0]      pending,
  output logic [ste_pkg::HOUT_W-1:0]      cell_height,
  output logic [ste_pkg::SHADE_W-1:0]     shade,
  output logic                            saturated
);
  import ste_pkg::*;

  localparam int NCELLS = MAX_COLS * MAX_ROWS;
  localparam int AW     = $clog2(NCELLS);
  localparam int CW     = $clog2(MAX_COLS);
  localparam int RW     = $clog2(MAX_ROWS);
  localparam int QW     = CW + RW;
  localparam int CNTW   = AW + 1;
  localparam int HB     = HEIGHT_BITS;
  localparam int DVW    = (HB > 16) ? HB : 16;
  localparam int DCW    = $clog2(DVW + 1);
  localparam int SW     = ((HB > GRAIN_W) ? HB : GRAIN_W) + 1;
  localparam int PW     = HB + WEIGHT_W;
  localparam int NW     = PW + 1;
  localparam logic [HB-1:0] HMAX = {HB{1'b1}};

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c, input logic [RW-1:0] r);
    return AW'(32'(c) * 32'(MAX_ROWS) + 32'(r));
  endfunction

  // configuration registers
  logic [GRID_W-1:0] grid_width;
  logic [GRID_W-1:0] grid_height;
  logic [KW_W-1:0]   kweights;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= RST_GRID_WIDTH;
      grid_height <= RST_GRID_HEIGHT;
      kweights    <= RST_KERNEL;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data[GRID_W-1:0];
        CFG_GRID_HEIGHT: grid_height <= cfg_data[GRID_W-1:0];
        CFG_KERNEL:      kweights    <= cfg_data[KW_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped grid size and kernel sum
  logic [CW:0]      act_cols;
  logic [RW:0]      act_rows;
  logic [SUM_W-1:0] ksum;

  always_comb begin
    if (grid_width == '0) act_cols = (CW+1)'(1);
    else if (32'(grid_width) > 32'(MAX_COLS)) act_cols = (CW+1)'(MAX_COLS);
    else act_cols = (CW+1)'(grid_width);
    if (grid_height == '0) act_rows = (RW+1)'(1);
    else if (32'(grid_height) > 32'(MAX_ROWS)) act_rows = (RW+1)'(MAX_ROWS);
    else act_rows = (RW+1)'(grid_height);
    ksum = kernel_sum(kweights);
  end

  // state and working registers
  state_t            state, state_next;
  logic [CW-1:0]     cur_c;
  logic [RW-1:0]     cur_r;
  logic [GRAIN_W-1:0] grains_reg;
  logic [LIMIT_W-1:0] limit_reg;
  logic [LIMIT_W-1:0] pcnt;
  logic [HB-1:0]     q_reg;
  logic [PW-1:0]     prod;
  logic [AW-1:0]     nb_addr_reg;
  logic [1:0]        dc, dr;
  logic [AW-1:0]     qhead, qtail, sweep;
  logic [CNTW-1:0]   qcount;
  logic              ovf;
  logic [HOUT_W-1:0] res_h;
  logic [SHADE_W-1:0] res_shade;

  // serial divider by the kernel sum
  logic [DVW-1:0]   dvd;
  logic [SUM_W-1:0] rem;
  logic [DCW-1:0]   div_cnt;
  logic             div_start;
  logic [DVW-1:0]   div_in;
  logic [SUM_W:0]   trial;

  // memories
  logic [HB:0]   cell_mem [NCELLS];
  logic [QW-1:0] q_mem [NCELLS];
  logic          cell_re, cell_we, q_re, q_we;
  logic [AW-1:0] cell_raddr, cell_waddr;
  logic [HB:0]   cell_wdata, cell_rdata;
  logic [QW-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
    if (cell_re) cell_rdata <= cell_mem[cell_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[qtail] <= q_wdata;
    if (q_re) q_rdata <= q_mem[qhead];
  end

  // derived control terms
  logic          in_acc, in_grid, q_room, pop_ok, topple, k_last, nb_ok, sweep_last, qa_last;
  logic          rd_mark;
  logic [HB-1:0] rd_h;
  logic [AW-1:0] cur_addr, nb_addr;
  logic [CW:0]   nc_w;
  logic [RW:0]   nr_w;
  logic [WEIGHT_W-1:0] widx;
  logic [WEIGHT_W-1:0] weight;
  logic [SW-1:0] add_sum;
  logic          add_sat;
  logic [HB-1:0] add_new;
  logic [NW-1:0] nb_sum;
  logic          nb_sat;
  logic [HB-1:0] nb_new;
  logic          push;
  logic [15:0]   shade_dvd;

  always_comb begin
    in_stall   = (state != ST_IDLE);
    in_acc     = in_valid && !in_stall;
    in_grid    = (32'(col) < 32'(act_cols)) && (32'(row) < 32'(act_rows));
    q_room     = qcount < CNTW'(NCELLS);
    pop_ok     = (pcnt < limit_reg) && (qcount != '0);
    rd_mark    = cell_rdata[HB];
    rd_h       = cell_rdata[HB-1:0];
    cur_addr   = cell_addr(cur_c, cur_r);
    topple     = ((CW+1)'(cur_c) < act_cols) && ((RW+1)'(cur_r) < act_rows)
                 && (ksum != '0) && (rd_h >= HB'(ksum));
    k_last     = (dc == 2'd2) && (dr == 2'd2);
    sweep_last = (sweep == AW'(NCELLS - 1));
    qa_last    = (((RW+1)'(cur_r) + (RW+1)'(1)) == act_rows)
                 && (((CW+1)'(cur_c) + (CW+1)'(1)) == act_cols);
    // neighbour position and weight
    nc_w    = (CW+1)'(cur_c) + (CW+1)'(dc);
    nr_w    = (RW+1)'(cur_r) + (RW+1)'(dr);
    nb_ok   = (nc_w != '0) && (nr_w != '0)
              && ((nc_w - (CW+1)'(1)) < act_cols) && ((nr_w - (RW+1)'(1)) < act_rows);
    nb_addr = cell_addr(CW'(nc_w - (CW+1)'(1)), RW'(nr_w - (RW+1)'(1)));
    widx    = {2'b00, dc} * 4'd3 + {2'b00, dr};
    weight  = kweights[{widx, 2'b00} +: WEIGHT_W];
    // saturating sums
    add_sum = SW'(rd_h) + SW'(grains_reg);
    add_sat = add_sum > SW'(HMAX);
    add_new = add_sat ? HMAX : add_sum[HB-1:0];
    nb_sum  = NW'(rd_h) + NW'(prod);
    nb_sat  = nb_sum > NW'(HMAX);
    nb_new  = nb_sat ? HMAX : nb_sum[HB-1:0];
    push    = !rd_mark && q_room;
    shade_dvd = ({8'd0, rem} << 8) - {8'd0, rem};
    trial   = {rem, dvd[DVW-1]};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: if (sweep_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          case (mode)
            MODE_ADD:   state_next = in_grid ? ST_ADD_WR : ST_DONE;
            MODE_QALL:  state_next = ST_QA_RD;
            MODE_RUN:   state_next = ST_POP_CHK;
            MODE_READ:  state_next = in_grid ? ST_RD_CELL : ST_DONE;
            MODE_CLEAR: state_next = ST_CLR_RD;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_ADD_WR:   state_next = ST_DONE;
      ST_QA_RD:    state_next = ST_QA_WR;
      ST_QA_WR:    state_next = qa_last ? ST_DONE : ST_QA_RD;
      ST_POP_CHK:  state_next = pop_ok ? ST_POP_Q : ST_DONE;
      ST_POP_Q:    state_next = ST_POP_CELL;
      ST_POP_CELL: state_next = topple ? ST_TOP_DIV : ST_POP_CHK;
      ST_TOP_DIV:  if (div_cnt == '0) state_next = ST_NB_RD;
      ST_NB_RD: begin
        if (nb_ok) state_next = ST_NB_WR;
        else if (k_last) state_next = ST_POP_CHK;
      end
      ST_NB_WR:    state_next = k_last ? ST_POP_CHK : ST_NB_RD;
      ST_RD_CELL:  state_next = (ksum == '0) ? ST_DONE : ST_RD_DIV1;
      ST_RD_DIV1:  if (div_cnt == '0) state_next = ST_RD_DIV2;
      ST_RD_DIV2:  if (div_cnt == '0) state_next = ST_DONE;
      ST_CLR_RD:   state_next = ST_CLR_WR;
      ST_CLR_WR:   state_next = sweep_last ? ST_DONE : ST_CLR_RD;
      ST_DONE:     if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // memory and divider controls
  always_comb begin
    cell_re    = 1'b0;
    cell_raddr = cur_addr;
    cell_we    = 1'b0;
    cell_waddr = cur_addr;
    cell_wdata = '0;
    q_re       = 1'b0;
    q_we       = 1'b0;
    q_wdata    = {cur_c, cur_r};
    div_start  = 1'b0;
    div_in     = DVW'(rd_h);
    case (state)
      ST_INIT: begin
        cell_we    = 1'b1;
        cell_waddr = sweep;
      end
      ST_IDLE: begin
        if (in_acc && in_grid && (mode == MODE_ADD || mode == MODE_READ)) begin
          cell_re    = 1'b1;
          cell_raddr = cell_addr(CW'(col), RW'(row));
        end
      end
      ST_ADD_WR: begin
        cell_we    = 1'b1;
        cell_wdata = {rd_mark | q_room, add_new};
        q_we       = push;
      end
      ST_QA_RD: cell_re = 1'b1;
      ST_QA_WR: begin
        cell_we    = push;
        cell_wdata = {1'b1, rd_h};
        q_we       = push;
      end
      ST_POP_CHK: q_re = pop_ok;
      ST_POP_Q: begin
        cell_re    = 1'b1;
        cell_raddr = cell_addr(q_rdata[QW-1:RW], q_rdata[RW-1:0]);
      end
      ST_POP_CELL: begin
        cell_we    = !topple;
        cell_wdata = {1'b0, rd_h};
        div_start  = topple;
      end
      ST_TOP_DIV: begin
        cell_we    = (div_cnt == '0);
        cell_wdata = {1'b0, HB'(rem)};
      end
      ST_NB_RD: begin
        cell_re    = nb_ok;
        cell_raddr = nb_addr;
      end
      ST_NB_WR: begin
        cell_we    = 1'b1;
        cell_waddr = nb_addr_reg;
        cell_wdata = {rd_mark | q_room, nb_new};
        q_we       = push;
        // neighbour offsets still hold for this tap
        q_wdata    = {CW'(nc_w - (CW+1)'(1)), RW'(nr_w - (RW+1)'(1))};
      end
      ST_RD_CELL: div_start = (ksum != '0);
      ST_RD_DIV1: begin
        div_start = (div_cnt == '0);
        div_in    = DVW'(shade_dvd);
      end
      ST_CLR_RD: begin
        cell_re    = 1'b1;
        cell_raddr = sweep;
      end
      ST_CLR_WR: begin
        cell_we    = 1'b1;
        cell_waddr = sweep;
        cell_wdata = {rd_mark, HB'(0)};
      end
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_INIT;
    else state <= state_next;
  end

  // divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (div_start) begin
      dvd     <= div_in;
      rem     <= '0;
      div_cnt <= DCW'(DVW);
    end else if (div_cnt != '0) begin
      if (trial >= {1'b0, ksum}) begin
        rem <= SUM_W'(trial - {1'b0, ksum});
        dvd <= {dvd[DVW-2:0], 1'b1};
      end else begin
        rem <= SUM_W'(trial);
        dvd <= {dvd[DVW-2:0], 1'b0};
      end
      div_cnt <= div_cnt - DCW'(1);
    end
  end

  // queue pointers, flags and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      qhead  <= '0;
      qtail  <= '0;
      qcount <= '0;
      ovf    <= 1'b0;
      sweep  <= '0;
    end else begin
      if (q_we) begin
        qtail  <= (qtail == AW'(NCELLS - 1)) ? '0 : qtail + AW'(1);
        qcount <= qcount + CNTW'(1);
      end
      if (q_re) begin
        qhead  <= (qhead == AW'(NCELLS - 1)) ? '0 : qhead + AW'(1);
        qcount <= qcount - CNTW'(1);
      end
      if ((state == ST_ADD_WR && add_sat) || (state == ST_NB_WR && nb_sat)) ovf <= 1'b1;
      if (state == ST_INIT || state == ST_CLR_WR) sweep <= sweep + AW'(1);
      else if (state == ST_IDLE) sweep <= '0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          cur_c      <= (mode == MODE_QALL) ? '0 : CW'(col);
          cur_r      <= (mode == MODE_QALL) ? '0 : RW'(row);
          grains_reg <= grains;
          limit_reg  <= pop_limit;
          pcnt       <= '0;
          res_h      <= '0;
          res_shade  <= '0;
        end
      end
      ST_QA_WR: begin
        if (((RW+1)'(cur_r) + (RW+1)'(1)) == act_rows) begin
          cur_r <= '0;
          cur_c <= cur_c + CW'(1);
        end else begin
          cur_r <= cur_r + RW'(1);
        end
      end
      ST_POP_CHK: if (pop_ok) pcnt <= pcnt + LIMIT_W'(1);
      ST_POP_Q: begin
        cur_c <= q_rdata[QW-1:RW];
        cur_r <= q_rdata[RW-1:0];
      end
      ST_TOP_DIV: begin
        q_reg <= dvd[HB-1:0];
        dc    <= '0;
        dr    <= '0;
      end
      ST_NB_RD: begin
        nb_addr_reg <= nb_addr;
        prod        <= PW'(q_reg) * PW'(weight);
        if (!nb_ok) begin
          if (dr == 2'd2) begin
            dr <= '0;
            dc <= dc + 2'd1;
          end else begin
            dr <= dr + 2'd1;
          end
        end
      end
      ST_NB_WR: begin
        if (dr == 2'd2) begin
          dr <= '0;
          dc <= dc + 2'd1;
        end else begin
          dr <= dr + 2'd1;
        end
      end
      ST_RD_CELL: res_h <= HOUT_W'(rd_h);
      ST_RD_DIV2: if (div_cnt == '0) res_shade <= dvd[SHADE_W-1:0];
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      pending     <= PEND_W'(qcount);
      cell_height <= res_h;
      shade       <= res_shade;
      saturated   <= ovf;
    end
  end

endmodule

`default_nettype wire

>>> sv/ste_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ste_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [ste_pkg::PEND_W-1:0]  pending,
  input logic [ste_pkg::HOUT_W-1:0]  cell_height,
  input logic [ste_pkg::SHADE_W-1:0] shade,
  input logic                        saturated
);
  import ste_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pending) && $stable(cell_height))
    else $error("stalled result changed");

  // the block is busy in the cycle after it accepts a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // an empty cell has no shade
  a_shade_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && cell_height == '0 |-> shade == '0)
    else $error("shade without height");

  // the saturation flag is sticky
  a_sat_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(saturated) |-> saturated)
    else $error("saturation flag dropped");

endmodule

bind sandpile_topple_engine_unit ste_checker u_ste_checker (.*);

`default_nettype wire
